>>> hw/rtl/rbpa_pkg.sv
// rbpa_pkg: shared types and codes of the block pool allocator
// used by rbpa_mod and randomized_block_pool_allocator; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rbpa_pkg;

  localparam int unsigned DvdW = 32;
  localparam int unsigned DivW = 17;
  localparam int unsigned AddrW = 48;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StTooLarge   = 3'd1,
    StEmpty      = 3'd2,
    StMisaligned = 3'd3,
    StNotInPool  = 3'd4,
    StFull       = 3'd5,
    StDoubleFree = 3'd6,
    StBadAlign   = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CfgBlockOrder = 2'd0,
    CfgPoolBase   = 2'd1,
    CfgDfCheck    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    SInit,
    SIdle,
    SAChk0,
    SADiv1,
    SARd,
    SAChk,
    SAMove,
    SADiv2,
    SFChk,
    SFScan,
    SFPush
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/randomized_block_pool_allocator.sv
// randomized_block_pool_allocator: fixed-size block pool with a randomized free stack
// depends on rbpa_pkg, rbpa_ram, rbpa_mod
//
// channel   direction  handshake                 payload
// cfg       in         cfg_we_i                  cfg_idx_i, cfg_data_i
// item      in         start && !busy            kind_i .. free_addr_i
// result    out        result_valid_o (1 cycle)  status_o, alloc_addr_o, free_count_o
//
// allocate: two 32-step passes of the serial modulo unit, unless a check fails first
// free: check then push, with the double free scan between them when it runs
// the scan reads one free stack entry a cycle through the ram read port
// after reset the free stack is filled, with busy high
// results are registered and cannot be stalled; the next item may start meanwhile
`timescale 1ns / 1ps
`default_nettype none
module randomized_block_pool_allocator #(
  parameter int unsigned BLOCKS = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [47:0]                    cfg_data_i,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           kind_i,
  input  wire logic [16:0]                    request_size_i,
  input  wire logic [16:0]                    alignment_i,
  input  wire logic [31:0]                    pick_random_i,
  input  wire logic [31:0]                    offset_random_i,
  input  wire logic [47:0]                    free_addr_i,
  output logic                                result_valid_o,
  output logic [2:0]                          status_o,
  output logic [47:0]                         alloc_addr_o,
  output logic [$clog2(BLOCKS+1)-1:0]         free_count_o
);

  localparam int unsigned CW = $clog2(BLOCKS + 1);
  localparam int unsigned IW = $clog2(BLOCKS);

  rbpa_pkg::state_e state_q, state_d;

  logic [4:0]  order_q;
  logic [47:0] base_q;
  logic        dfc_q;

  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] init_q;
  logic [CW-1:0] scan_q;
  logic          pend_q, last_q;

  logic        kind_q;
  logic [16:0] size_q, align_q, mask_q;
  logic [31:0] prand_q, orand_q;
  logic [47:0] faddr_q, block_q;
  logic [IW-1:0] slot_q, idx_q;

  logic [4:0]  eff;
  logic [16:0] bsize, align_eff;
  logic [47:0] block, rel, hi;
  logic        not_in_pool;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr, ram_wdata, ram_rdata;

  rbpa_pkg::div_req_t div_req;
  rbpa_pkg::div_rsp_t div_rsp;

  logic              resp;
  rbpa_pkg::status_e resp_st;
  logic [47:0]       resp_addr;
  logic              scan_issue;

  rbpa_ram #(
    .WIDTH(IW),
    .DEPTH(BLOCKS)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rbpa_mod u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    if (order_q < 5'd3) begin
      eff = 5'd3;
    end else if (order_q > 5'd16) begin
      eff = 5'd16;
    end else begin
      eff = order_q;
    end
    bsize       = 17'd1 << eff;
    align_eff   = (align_q == 17'd0) ? 17'd8 : align_q;
    block       = base_q + (48'(ram_rdata) << eff);
    rel         = faddr_q - base_q;
    hi          = rel >> eff;
    not_in_pool = (faddr_q < base_q) || (hi >= 48'(BLOCKS)) ||
                  ((faddr_q[16:0] & (bsize - 17'd1)) != 17'd0);
    scan_issue  = (scan_q < count_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rbpa_pkg::SInit: begin
        if (init_q == IW'(BLOCKS - 1)) state_d = rbpa_pkg::SIdle;
      end
      rbpa_pkg::SIdle: begin
        if (start) state_d = kind_i ? rbpa_pkg::SFChk : rbpa_pkg::SAChk0;
      end
      rbpa_pkg::SAChk0: begin
        if ((size_q > bsize) || ((align_eff & (align_eff - 17'd1)) != 17'd0) ||
            (count_q == '0)) begin
          state_d = rbpa_pkg::SIdle;
        end else begin
          state_d = rbpa_pkg::SADiv1;
        end
      end
      rbpa_pkg::SADiv1: begin
        if (div_rsp.done) state_d = rbpa_pkg::SARd;
      end
      rbpa_pkg::SARd: state_d = rbpa_pkg::SAChk;
      rbpa_pkg::SAChk: begin
        if ((block[16:0] & mask_q) != 17'd0) state_d = rbpa_pkg::SIdle;
        else state_d = rbpa_pkg::SAMove;
      end
      rbpa_pkg::SAMove: state_d = rbpa_pkg::SADiv2;
      rbpa_pkg::SADiv2: begin
        if (div_rsp.done) state_d = rbpa_pkg::SIdle;
      end
      rbpa_pkg::SFChk: begin
        if (not_in_pool || (count_q >= CW'(BLOCKS))) state_d = rbpa_pkg::SIdle;
        else if (dfc_q && (count_q != '0)) state_d = rbpa_pkg::SFScan;
        else state_d = rbpa_pkg::SFPush;
      end
      rbpa_pkg::SFScan: begin
        if (pend_q && (ram_rdata == idx_q)) state_d = rbpa_pkg::SIdle;
        else if (pend_q && last_q) state_d = rbpa_pkg::SFPush;
      end
      rbpa_pkg::SFPush: state_d = rbpa_pkg::SIdle;
      default: state_d = rbpa_pkg::SIdle;
    endcase
  end

  always_comb begin
    ram_we           = 1'b0;
    ram_waddr        = init_q;
    ram_wdata        = init_q;
    ram_re           = 1'b0;
    ram_raddr        = slot_q;
    div_req.start    = 1'b0;
    div_req.dividend = prand_q;
    div_req.divisor  = 17'(count_q);
    resp             = 1'b0;
    resp_st          = rbpa_pkg::StOk;
    resp_addr        = '0;
    count_d          = count_q;
    case (state_q)
      rbpa_pkg::SInit: begin
        ram_we = 1'b1;
      end
      rbpa_pkg::SAChk0: begin
        if (size_q > bsize) begin
          resp    = 1'b1;
          resp_st = rbpa_pkg::StTooLarge;
        end else if ((align_eff & (align_eff - 17'd1)) != 17'd0) begin
          resp    = 1'b1;
          resp_st = rbpa_pkg::StBadAlign;
        end else if (count_q == '0) begin
          resp    = 1'b1;
          resp_st = rbpa_pkg::StEmpty;
        end else begin
          div_req.start = 1'b1;
        end
      end
      rbpa_pkg::SARd: begin
        ram_re = 1'b1;
      end
      rbpa_pkg::SAChk: begin
        if ((block[16:0] & mask_q) != 17'd0) begin
          resp    = 1'b1;
          resp_st = rbpa_pkg::StMisaligned;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IW'(count_q - CW'(1));
        end
      end
      rbpa_pkg::SAMove: begin
        ram_we           = 1'b1;
        ram_waddr        = slot_q;
        ram_wdata        = ram_rdata;
        count_d          = count_q - CW'(1);
        div_req.start    = 1'b1;
        div_req.dividend = orand_q;
        div_req.divisor  = bsize - size_q + 17'd1;
      end
      rbpa_pkg::SADiv2: begin
        if (div_rsp.done) begin
          resp      = 1'b1;
          resp_addr = (block_q + 48'(div_rsp.rem)) & ~48'(mask_q);
        end
      end
      rbpa_pkg::SFChk: begin
        if (not_in_pool) begin
          resp    = 1'b1;
          resp_st = rbpa_pkg::StNotInPool;
        end else if (count_q >= CW'(BLOCKS)) begin
          resp    = 1'b1;
          resp_st = rbpa_pkg::StFull;
        end
      end
      rbpa_pkg::SFScan: begin
        ram_re    = scan_issue;
        ram_raddr = scan_q[IW-1:0];
        if (pend_q && (ram_rdata == idx_q)) begin
          resp    = 1'b1;
          resp_st = rbpa_pkg::StDoubleFree;
        end
      end
      rbpa_pkg::SFPush: begin
        ram_we    = 1'b1;
        ram_waddr = count_q[IW-1:0];
        ram_wdata = idx_q;
        count_d   = count_q + CW'(1);
        resp      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state_q != rbpa_pkg::SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= rbpa_pkg::SInit;
      count_q        <= CW'(BLOCKS);
      init_q         <= '0;
      scan_q         <= '0;
      pend_q         <= 1'b0;
      last_q         <= 1'b0;
      order_q        <= 5'd12;
      base_q         <= '0;
      dfc_q          <= 1'b1;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      result_valid_o <= resp;
      if (state_q == rbpa_pkg::SInit) init_q <= init_q + IW'(1);
      if (state_q == rbpa_pkg::SFScan) begin
        pend_q <= scan_issue;
        last_q <= (scan_q == count_q - CW'(1));
        if (scan_issue) scan_q <= scan_q + CW'(1);
      end else begin
        scan_q <= '0;
        pend_q <= 1'b0;
        last_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rbpa_pkg::CfgBlockOrder: order_q <= cfg_data_i[4:0];
          rbpa_pkg::CfgPoolBase:   base_q  <= cfg_data_i;
          rbpa_pkg::CfgDfCheck:    dfc_q   <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rbpa_pkg::SIdle && start) begin
      kind_q  <= kind_i;
      size_q  <= request_size_i;
      align_q <= alignment_i;
      prand_q <= pick_random_i;
      orand_q <= offset_random_i;
      faddr_q <= free_addr_i;
    end
    if (state_q == rbpa_pkg::SAChk0) mask_q <= align_eff - 17'd1;
    if (state_q == rbpa_pkg::SADiv1 && div_rsp.done) slot_q <= div_rsp.rem[IW-1:0];
    if (state_q == rbpa_pkg::SAChk) block_q <= block;
    if (state_q == rbpa_pkg::SFChk) idx_q <= hi[IW-1:0];
    if (resp) begin
      status_o     <= resp_st;
      alloc_addr_o <= kind_q ? 48'd0 : resp_addr;
      free_count_o <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(BLOCKS))
    else $error("free count above pool size");

  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q != rbpa_pkg::SIdle))
    else $error("result without an item in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbpa_pkg::SFPush) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push did not grow the free count");

endmodule
`default_nettype wire

>>> hw/rtl/rbpa_ram.sv
// rbpa_ram: generic simple dual-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module rbpa_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rbpa_mod.sv
// rbpa_mod: bit-serial restoring modulo unit, one quotient bit per cycle
// depends on rbpa_pkg
`timescale 1ns / 1ps
`default_nettype none
module rbpa_mod (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rbpa_pkg::div_req_t req_i,
  output rbpa_pkg::div_rsp_t     rsp_o
);

  logic                      run_q;
  logic [4:0]                cnt_q;
  logic [rbpa_pkg::DvdW-1:0] dvd_q;
  logic [rbpa_pkg::DivW-1:0] dsr_q;
  logic [rbpa_pkg::DivW-1:0] rem_q;
  logic [rbpa_pkg::DivW-1:0] rem_d;
  logic                      done_q;
  logic [rbpa_pkg::DivW:0]   trial;

  always_comb begin
    trial = {rem_q, dvd_q[rbpa_pkg::DvdW-1]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = rbpa_pkg::DivW'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = trial[rbpa_pkg::DivW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !run_q) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !run_q) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[rbpa_pkg::DvdW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire
